// ===== hdl/csp_pkg.sv =====
`default_nettype none

package csp_pkg;

  localparam int unsigned DefStackDepth    = 64;
  localparam int unsigned DefFunctionCount = 1024;
  localparam int unsigned DefMetricBits    = 48;

  localparam int unsigned IdBits    = 10;
  localparam int unsigned LevelBits = 16;
  localparam int unsigned RecBits   = 6;
  localparam int unsigned CallBits  = 32;
  localparam int unsigned TotalBits = 56;
  localparam int unsigned LimitBits = 7;
  localparam int unsigned KindBits  = 2;

  typedef enum logic [KindBits-1:0] {
    KIND_START     = 2'd0,
    KIND_END       = 2'd1,
    KIND_SKIP      = 2'd2,
    KIND_UNDERFLOW = 2'd3
  } kind_e;

  localparam logic CMD_ENTER  = 1'b0;
  localparam logic CMD_RETURN = 1'b1;

  localparam logic [LimitBits-1:0] LimitReset = 7'd64;
  localparam logic [LevelBits-1:0] LevelMax   = '1;
  localparam logic [RecBits-1:0]   RecMax     = '1;

endpackage

`default_nettype wire

// ===== hdl/csp_ram.sv =====
`default_nettype none

module csp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/call_stack_profiler_unit.sv =====
// Channel   Direction  Handshake               Payload
// config    in/out     psel/penable/pready     paddr, pwdata, prdata (depth_limit at 0x0)
// event     in         in_valid_i/in_stall_o   command_i, function_id_i, metric_sample_i
// result    out        out_valid_o/out_stall_i event_kind_o .. cumulative_cost_o
//
// Steps: skipped calls/returns and underflow load the result at accept, a profiled
//   entry writes its frame and reads the caller's; on a profiled return the frame
//   stack RAM port walks one frame per cycle down to the bottom looking for recursion.
// Reset: the per-function statistics RAM is swept to zero, one entry per cycle,
//   after reset; no item is taken meanwhile.
// Stalls: one item at a time; a new item is taken once the result register is
//   free or being drained.
`default_nettype none

module call_stack_profiler_unit
  import csp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH    = DefStackDepth,
  parameter int unsigned FUNCTION_COUNT = DefFunctionCount,
  parameter int unsigned METRIC_BITS    = DefMetricBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic [IdBits-1:0]      function_id_i,
  input  logic [METRIC_BITS-1:0] metric_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [KindBits-1:0]    event_kind_o,
  output logic                   caller_present_o,
  output logic [IdBits-1:0]      caller_id_o,
  output logic [IdBits-1:0]      callee_id_o,
  output logic [LevelBits-1:0]   stack_level_o,
  output logic [METRIC_BITS-1:0] inclusive_cost_o,
  output logic [METRIC_BITS-1:0] exclusive_cost_o,
  output logic [RecBits-1:0]     recursion_depth_o,
  output logic [CallBits-1:0]    function_calls_o,
  output logic [TotalBits-1:0]   function_inclusive_total_o,
  output logic [TotalBits-1:0]   function_exclusive_total_o,
  output logic [METRIC_BITS-1:0] cumulative_cost_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned IW = $clog2(FUNCTION_COUNT);
  localparam int unsigned MB = METRIC_BITS;
  localparam int unsigned FW = IdBits + 2 * MB;                  // frame: fn, start, children
  localparam int unsigned SW = CallBits + RecBits + 2 * TotalBits; // stats entry
  localparam int unsigned WB = (MB > TotalBits) ? MB : TotalBits;
  localparam logic [LevelBits-1:0] DepthLevel = LevelBits'(STACK_DEPTH);
  localparam logic [IW-1:0]        LastFn     = IW'(FUNCTION_COUNT - 1);
  localparam logic                 RegDepthLimit = 1'b0;          // paddr[2] selects register

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CALL  = 10'b0000000100,
    S_CALLW = 10'b0000001000,
    S_TOP   = 10'b0000010000,
    S_TOPW  = 10'b0000100000,
    S_EXC   = 10'b0001000000,
    S_WALK  = 10'b0010000000,
    S_STATR = 10'b0100000000,
    S_STATW = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic                 cp;
    logic [IdBits-1:0]    cid;
    logic [IdBits-1:0]    callee;
    logic [LevelBits-1:0] level;
    logic [MB-1:0]        inc;
    logic [MB-1:0]        exc;
    logic [RecBits-1:0]   rec;
    logic [CallBits-1:0]  calls;
    logic [TotalBits-1:0] itot;
    logic [TotalBits-1:0] etot;
    logic [MB-1:0]        cum;
  } result_t;

  // function id folded into the statistics range by constant compare/subtract
  function automatic logic [IW-1:0] fn_index(logic [IdBits-1:0] id);
    logic [31:0] v;
    v = 32'(id);
    for (int k = IdBits - 1; k >= 0; k--) begin
      if (((32'(FUNCTION_COUNT) << k) <= 32'((1 << IdBits) - 1)) &&
          (v >= (32'(FUNCTION_COUNT) << k))) begin
        v = v - (32'(FUNCTION_COUNT) << k);
      end
    end
    return IW'(v);
  endfunction

  // skipped and underflow items: kind, callee and level, all else zero
  function automatic result_t short_res(logic [KindBits-1:0] kind,
                                        logic [IdBits-1:0] callee,
                                        logic [LevelBits-1:0] level);
    result_t r;
    r        = '0;
    r.kind   = kind;
    r.callee = callee;
    r.level  = level;
    return r;
  endfunction

  state_e               state_q;
  logic [LimitBits-1:0] limit_q;
  logic [LevelBits-1:0] count_q;
  logic [MB-1:0]        first_q;
  logic [CallBits-1:0]  prof_q;
  logic [IW-1:0]        clr_q;

  logic [IdBits-1:0]    fid_q;
  logic [MB-1:0]        sample_q;
  logic [AW-1:0]        d_q;
  logic [IdBits-1:0]    me_q;
  logic [MB-1:0]        inc_q;
  logic [MB-1:0]        ch_q;
  logic [MB-1:0]        exc_q;
  logic [AW-1:0]        ip_q;
  logic                 more_q;
  logic                 pv_q;
  logic [AW-1:0]        pa_q;
  logic [RecBits-1:0]   rec_q;
  logic [IdBits-1:0]    caller_q;

  logic                 out_valid_q;
  result_t              out_q;

  // config port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegDepthLimit);
  assign prdata = (paddr[2] == RegDepthLimit) ? 32'(limit_q) : 32'd0;

  logic [LevelBits-1:0] limit_eff;
  assign limit_eff = ((limit_q == '0) || (LevelBits'(limit_q) > DepthLevel)) ?
                     DepthLevel : LevelBits'(limit_q);

  logic accept;
  logic out_take;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // frame stack RAM
  logic          frm_we;
  logic [AW-1:0] frm_waddr;
  logic [FW-1:0] frm_wdata;
  logic [AW-1:0] frm_raddr;
  logic [FW-1:0] frm_rdata;

  csp_ram #(.Width(FW), .Depth(STACK_DEPTH)) u_frames (
    .clk_i  (clk_i),
    .we_i   (frm_we),
    .waddr_i(frm_waddr),
    .wdata_i(frm_wdata),
    .raddr_i(frm_raddr),
    .rdata_o(frm_rdata)
  );

  // per-function statistics RAM
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [SW-1:0] st_wdata;
  logic [IW-1:0] st_raddr;
  logic [SW-1:0] st_rdata;

  csp_ram #(.Width(SW), .Depth(FUNCTION_COUNT)) u_stats (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  logic [IdBits-1:0] rd_fn;
  logic [MB-1:0]     rd_start;
  logic [MB-1:0]     rd_ch;
  assign rd_fn    = frm_rdata[FW-1 -: IdBits];
  assign rd_start = frm_rdata[2*MB-1:MB];
  assign rd_ch    = frm_rdata[MB-1:0];

  // walk step: the parent gets the inclusive cost, the nearest frame of the same
  // function gets the exclusive cost back (inc - exc folds to the child sum)
  logic          w_match;
  logic          w_top;
  logic [MB-1:0] w_delta;
  logic          w_write;
  assign w_match = (rd_fn == me_q);
  assign w_top   = (pa_q == (d_q - AW'(1)));
  assign w_delta = w_top ? (w_match ? ch_q : inc_q) : (MB'(0) - exc_q);
  assign w_write = pv_q && (w_top || (w_match && (rec_q == '0)));

  logic [IW-1:0] idx;
  assign idx = fn_index(me_q);

  logic [CallBits-1:0]  st_calls;
  logic [RecBits-1:0]   st_rec;
  logic [TotalBits-1:0] st_itot;
  logic [TotalBits-1:0] st_etot;
  logic [CallBits-1:0]  nx_calls;
  logic [RecBits-1:0]   nx_rec;
  logic [TotalBits-1:0] nx_itot;
  logic [TotalBits-1:0] nx_etot;
  logic [WB-1:0]        inc_w;
  logic [WB-1:0]        exc_w;

  assign st_calls = st_rdata[SW-1 -: CallBits];
  assign st_rec   = st_rdata[2*TotalBits +: RecBits];
  assign st_itot  = st_rdata[TotalBits +: TotalBits];
  assign st_etot  = st_rdata[TotalBits-1:0];
  assign inc_w    = WB'(inc_q);
  assign exc_w    = WB'(exc_q);
  assign nx_calls = st_calls + CallBits'(1);
  assign nx_rec   = (st_rec < rec_q) ? rec_q : st_rec;
  assign nx_itot  = (rec_q == '0) ? (st_itot + inc_w[TotalBits-1:0]) : st_itot;
  assign nx_etot  = (rec_q == '0) ? (st_etot + exc_w[TotalBits-1:0]) : st_etot;

  always_comb begin
    frm_we    = 1'b0;
    frm_waddr = d_q;
    frm_wdata = {fid_q, sample_q, MB'(0)};
    frm_raddr = d_q;
    st_we     = 1'b0;
    st_waddr  = idx;
    st_wdata  = {nx_calls, nx_rec, nx_itot, nx_etot};
    st_raddr  = idx;
    case (state_q)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
      end
      S_CALL: begin
        frm_we    = 1'b1;
        frm_raddr = d_q - AW'(1);
      end
      S_WALK: begin
        frm_we    = w_write;
        frm_waddr = pa_q;
        frm_wdata = {rd_fn, rd_start, rd_ch + w_delta};
        frm_raddr = ip_q;
      end
      S_STATW: st_we = 1'b1;
      default: ;
    endcase
  end

  logic [LevelBits-1:0] cnt_dn;
  logic [MB-1:0]        first_nx;
  assign cnt_dn   = count_q - LevelBits'(1);
  assign first_nx = (prof_q == '0) ? metric_sample_i : first_q;

  // a result is loaded on skipped/underflow items at accept, and at the end of
  // a profiled entry or return
  logic out_set;
  assign out_set = (state_q == S_CALLW) || (state_q == S_STATW) ||
                   (accept && ((command_i == CMD_ENTER) ? (count_q >= limit_eff) :
                               ((count_q == '0) || (cnt_dn >= limit_eff))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      limit_q     <= LimitReset;
      count_q     <= '0;
      first_q     <= '0;
      prof_q      <= '0;
      clr_q       <= '0;
      more_q      <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_q <= pwdata[LimitBits-1:0];
      end
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LastFn) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            fid_q    <= function_id_i;
            sample_q <= metric_sample_i;
            if (command_i == CMD_ENTER) begin
              if (count_q < limit_eff) begin
                first_q <= first_nx;
                prof_q  <= prof_q + CallBits'(1);
                d_q     <= count_q[AW-1:0];
                count_q <= count_q + LevelBits'(1);
                state_q <= S_CALL;
              end else begin
                out_q <= short_res(KIND_SKIP, function_id_i,
                                   (count_q != LevelMax) ? count_q + LevelBits'(1) : count_q);
                if (count_q != LevelMax) begin
                  count_q <= count_q + LevelBits'(1);
                end
              end
            end else if (count_q == '0) begin
              out_q <= short_res(KIND_UNDERFLOW, '0, '0);
            end else begin
              count_q <= cnt_dn;
              if (cnt_dn >= limit_eff) begin
                out_q <= short_res(KIND_SKIP, '0, cnt_dn);
              end else begin
                d_q     <= cnt_dn[AW-1:0];
                state_q <= S_TOP;
              end
            end
          end
        end
        S_CALL: state_q <= S_CALLW;
        S_CALLW: begin
          out_q   <= {KIND_START, (d_q != '0), ((d_q != '0) ? rd_fn : IdBits'(0)), fid_q,
                      LevelBits'(d_q) + LevelBits'(1), MB'(0), MB'(0), RecBits'(0),
                      CallBits'(0), TotalBits'(0), TotalBits'(0), MB'(sample_q - first_q)};
          state_q <= S_IDLE;
        end
        S_TOP: state_q <= S_TOPW;
        S_TOPW: begin
          me_q    <= rd_fn;
          inc_q   <= sample_q - rd_start;
          ch_q    <= rd_ch;
          state_q <= S_EXC;
        end
        S_EXC: begin
          exc_q    <= inc_q - ch_q;
          ip_q     <= d_q - AW'(1);
          more_q   <= (d_q != '0);
          pv_q     <= 1'b0;
          rec_q    <= '0;
          caller_q <= '0;
          state_q  <= S_WALK;
        end
        S_WALK: begin
          // issue one read per cycle; data is checked the cycle after
          if (more_q) begin
            ip_q   <= ip_q - AW'(1);
            more_q <= (ip_q != '0);
          end
          pv_q <= more_q;
          pa_q <= ip_q;
          if (pv_q && w_top) begin
            caller_q <= rd_fn;
          end
          if (pv_q && w_match && (rec_q != RecMax)) begin
            rec_q <= rec_q + RecBits'(1);
          end
          if (!more_q && !pv_q) begin
            state_q <= S_STATR;
          end
        end
        S_STATR: state_q <= S_STATW;
        S_STATW: begin
          out_q   <= {KIND_END, (d_q != '0), caller_q, me_q, LevelBits'(d_q), inc_q, exc_q,
                      rec_q, nx_calls, nx_itot, nx_etot, MB'(sample_q - first_q)};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o                = out_valid_q;
  assign event_kind_o               = out_q.kind;
  assign caller_present_o           = out_q.cp;
  assign caller_id_o                = out_q.cid;
  assign callee_id_o                = out_q.callee;
  assign stack_level_o              = out_q.level;
  assign inclusive_cost_o           = out_q.inc;
  assign exclusive_cost_o           = out_q.exc;
  assign recursion_depth_o          = out_q.rec;
  assign function_calls_o           = out_q.calls;
  assign function_inclusive_total_o = out_q.itot;
  assign function_exclusive_total_o = out_q.etot;
  assign cumulative_cost_o          = out_q.cum;

endmodule

`default_nettype wire

// ===== hdl/csp_checker.sv =====
`default_nettype none

module csp_checker
  import csp_pkg::*;
#(
  parameter int unsigned METRIC_BITS = DefMetricBits
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [KindBits-1:0]    event_kind_o,
  input logic                   caller_present_o,
  input logic [IdBits-1:0]      caller_id_o,
  input logic [LevelBits-1:0]   stack_level_o,
  input logic [METRIC_BITS-1:0] inclusive_cost_o,
  input logic [RecBits-1:0]     recursion_depth_o
);

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == KIND_UNDERFLOW) |->
      !caller_present_o && (stack_level_o == '0))
    else $error("underflow item carries data");

  a_no_caller_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !caller_present_o |-> (caller_id_o == '0))
    else $error("caller id without caller");

  a_start_no_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == KIND_START) |->
      (inclusive_cost_o == '0) && (recursion_depth_o == '0) && (stack_level_o != '0))
    else $error("call start item with cost fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(event_kind_o) && $stable(stack_level_o))
    else $error("stalled item changed");

endmodule

bind call_stack_profiler_unit csp_checker #(.METRIC_BITS(METRIC_BITS)) u_csp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_kind_o     (event_kind_o),
  .caller_present_o (caller_present_o),
  .caller_id_o      (caller_id_o),
  .stack_level_o    (stack_level_o),
  .inclusive_cost_o (inclusive_cost_o),
  .recursion_depth_o(recursion_depth_o)
);

`default_nettype wire
